[hdl/ppdr_pkg.sv]
// Shared types, widths and codes for the permutation pair relabelling block.
package ppdr_pkg;

  // Field widths
  localparam int unsigned TypeW  = 2;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ImgW   = 8;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned LabelW = 9;

  // Default number of stored points
  localparam int unsigned MaxPointsDef = 256;

  // Reset value of the size register
  localparam logic [SizeW-1:0] SizeRst = 9'd256;

  // Request codes
  typedef enum logic [TypeW-1:0] {
    REQ_LOAD = 2'd0,
    REQ_RUN  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_POP,
    ST_FETCH,
    ST_VISIT,
    ST_PUSH_O,
    ST_FINISH,
    ST_WR_FETCH,
    ST_WR_MAPS,
    ST_WR_MAPO,
    ST_WR_STORE,
    ST_RESP
  } state_e;

  // One accepted request plus the current size setting
  typedef struct packed {
    req_type_e         req_type;
    logic [IdxW-1:0]   entry_index;
    logic [ImgW-1:0]   s_image;
    logic [ImgW-1:0]   o_image;
    logic [SizeW-1:0]  size;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              all_reached;
    logic [SizeW-1:0]  reached_count;
    logic [ImgW-1:0]   new_s;
    logic [ImgW-1:0]   new_o;
  } rsp_t;

endpackage

[hdl/ppdr_ram.sv]
// Generic single-port RAM with registered read data.
module ppdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write when enabled, and read the addressed entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ppdr_engine.sv]
// Sequencer and stores: point loads, depth-first walk, table rewrite and reads.
module ppdr_engine #(
  parameter int unsigned MAX_POINTS = ppdr_pkg::MaxPointsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ppdr_pkg::cmd_t  cmd_i,
  output logic            idle_o,
  output logic            done_o,
  output ppdr_pkg::rsp_t  rsp_o
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned SW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SPW = $clog2(MAX_POINTS + 2);
  localparam int unsigned IW  = ppdr_pkg::ImgW;
  localparam int unsigned NW  = ppdr_pkg::SizeW;
  localparam int unsigned LW  = ppdr_pkg::LabelW;

  ppdr_pkg::state_e state_q, state_d;

  logic [NW-1:0]  n_q, n_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]  next_q, next_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [IW-1:0]  p_q, p_d;
  logic [IW-1:0]  s_img_q, s_img_d;
  logic [IW-1:0]  o_img_q, o_img_d;
  logic [LW-1:0]  lbl_q, lbl_d;
  logic [IW-1:0]  ms_q, ms_d;
  logic           idx_ok_q, idx_ok_d;
  ppdr_pkg::rsp_t rsp_q, rsp_d;

  // Memory ports
  logic            pt_we;
  logic [AW-1:0]   pt_addr;
  logic [IW-1:0]   pt_s_wdata, pt_o_wdata, pt_s_rdata, pt_o_rdata;
  logic            lab_we;
  logic [AW-1:0]   lab_addr;
  logic [LW:0]     lab_wdata, lab_rdata;
  logic            stk_we;
  logic [SW-1:0]   stk_addr;
  logic [IW-1:0]   stk_wdata, stk_rdata;
  logic            rel_we;
  logic [AW-1:0]   rel_addr;
  logic [IW-1:0]   rel_s_wdata, rel_o_wdata, rel_s_rdata, rel_o_rdata;

  logic [NW-1:0]   n_eff;
  logic            cmd_idx_ok;

  // Effective size: zero acts as one, clipped to the store depth
  always_comb begin
    if (cmd_i.size == '0) begin
      n_eff = NW'(1);
    end else if (32'(cmd_i.size) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = cmd_i.size;
    end
  end

  assign cmd_idx_ok = (32'(cmd_i.entry_index) < MAX_POINTS);

  // Stores
  ppdr_ram #(.Width(IW), .Depth(MAX_POINTS)) u_s_store (
    .clk_i, .we_i(pt_we), .addr_i(pt_addr), .wdata_i(pt_s_wdata), .rdata_o(pt_s_rdata)
  );
  ppdr_ram #(.Width(IW), .Depth(MAX_POINTS)) u_o_store (
    .clk_i, .we_i(pt_we), .addr_i(pt_addr), .wdata_i(pt_o_wdata), .rdata_o(pt_o_rdata)
  );
  // Label store: visited flag on top of the label
  ppdr_ram #(.Width(LW + 1), .Depth(MAX_POINTS)) u_label_store (
    .clk_i, .we_i(lab_we), .addr_i(lab_addr), .wdata_i(lab_wdata), .rdata_o(lab_rdata)
  );
  ppdr_ram #(.Width(IW), .Depth(MAX_POINTS + 1)) u_walk_stack (
    .clk_i, .we_i(stk_we), .addr_i(stk_addr), .wdata_i(stk_wdata), .rdata_o(stk_rdata)
  );
  ppdr_ram #(.Width(IW), .Depth(MAX_POINTS)) u_rel_s (
    .clk_i, .we_i(rel_we), .addr_i(rel_addr), .wdata_i(rel_s_wdata), .rdata_o(rel_s_rdata)
  );
  ppdr_ram #(.Width(IW), .Depth(MAX_POINTS)) u_rel_o (
    .clk_i, .we_i(rel_we), .addr_i(rel_addr), .wdata_i(rel_o_wdata), .rdata_o(rel_o_rdata)
  );

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppdr_pkg::ST_IDLE;
      sp_q    <= '0;
      cnt_q   <= '0;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      cnt_q   <= cnt_d;
      next_q  <= next_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    p_q      <= p_d;
    s_img_q  <= s_img_d;
    o_img_q  <= o_img_d;
    lbl_q    <= lbl_d;
    ms_q     <= ms_d;
    idx_ok_q <= idx_ok_d;
    rsp_q    <= rsp_d;
  end

  // Next state, memory controls
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    next_d      = next_q;
    sp_d        = sp_q;
    p_d         = p_q;
    s_img_d     = s_img_q;
    o_img_d     = o_img_q;
    lbl_d       = lbl_q;
    ms_d        = ms_q;
    idx_ok_d    = idx_ok_q;
    rsp_d       = rsp_q;
    pt_we       = 1'b0;
    pt_addr     = '0;
    pt_s_wdata  = cmd_i.s_image;
    pt_o_wdata  = cmd_i.o_image;
    lab_we      = 1'b0;
    lab_addr    = '0;
    lab_wdata   = '0;
    stk_we      = 1'b0;
    stk_addr    = '0;
    stk_wdata   = '0;
    rel_we      = 1'b0;
    rel_addr    = '0;
    rel_s_wdata = ms_q;
    rel_o_wdata = '0;

    case (state_q)
      ppdr_pkg::ST_IDLE: begin
        if (start_i) begin
          rsp_d = '0;
          case (cmd_i.req_type)
            ppdr_pkg::REQ_LOAD: begin
              pt_we   = cmd_idx_ok;
              pt_addr = AW'(cmd_i.entry_index);
              state_d = ppdr_pkg::ST_RESP;
            end
            ppdr_pkg::REQ_RUN: begin
              // seed the stack with point 0, then clear labels
              n_d       = n_eff;
              stk_we    = 1'b1;
              stk_addr  = '0;
              stk_wdata = '0;
              sp_d      = SPW'(1);
              next_d    = '0;
              cnt_d     = '0;
              state_d   = ppdr_pkg::ST_CLEAR;
            end
            ppdr_pkg::REQ_READ: begin
              rel_addr = AW'(cmd_i.entry_index);
              idx_ok_d = cmd_idx_ok;
              state_d  = ppdr_pkg::ST_READ_WAIT;
            end
            default: begin
              state_d = ppdr_pkg::ST_RESP;
            end
          endcase
        end
      end

      ppdr_pkg::ST_READ_WAIT: begin
        rsp_d.new_s = idx_ok_q ? rel_s_rdata : '0;
        rsp_d.new_o = idx_ok_q ? rel_o_rdata : '0;
        state_d     = ppdr_pkg::ST_RESP;
      end

      // Sweep label store to unvisited
      ppdr_pkg::ST_CLEAR: begin
        lab_we   = 1'b1;
        lab_addr = AW'(cnt_q);
        cnt_d    = cnt_q + NW'(1);
        if (cnt_q == n_q - NW'(1)) begin
          state_d = ppdr_pkg::ST_POP;
        end
      end

      // Pop top of stack
      ppdr_pkg::ST_POP: begin
        if (sp_q == '0) begin
          state_d = ppdr_pkg::ST_FINISH;
        end else begin
          stk_addr = SW'(sp_q - SPW'(1));
          sp_d     = sp_q - SPW'(1);
          state_d  = ppdr_pkg::ST_FETCH;
        end
      end

      // Popped point arrives; look up its label and successors
      ppdr_pkg::ST_FETCH: begin
        p_d      = stk_rdata;
        pt_addr  = AW'(stk_rdata);
        lab_addr = AW'(stk_rdata);
        if ({1'b0, stk_rdata} < n_q) begin
          state_d = ppdr_pkg::ST_VISIT;
        end else begin
          state_d = ppdr_pkg::ST_POP;
        end
      end

      // Label a new point, push S successor
      ppdr_pkg::ST_VISIT: begin
        if (lab_rdata[LW]) begin
          state_d = ppdr_pkg::ST_POP;
        end else begin
          lab_we    = 1'b1;
          lab_addr  = AW'(p_q);
          lab_wdata = {1'b1, next_q};
          next_d    = next_q + NW'(1);
          s_img_d   = pt_s_rdata;
          o_img_d   = pt_o_rdata;
          if ({1'b0, pt_s_rdata} < n_q) begin
            stk_we    = 1'b1;
            stk_addr  = SW'(sp_q);
            stk_wdata = pt_s_rdata;
            sp_d      = sp_q + SPW'(1);
          end
          state_d = ppdr_pkg::ST_PUSH_O;
        end
      end

      // Push O successor so it is explored first
      ppdr_pkg::ST_PUSH_O: begin
        if ({1'b0, o_img_q} < n_q) begin
          stk_we    = 1'b1;
          stk_addr  = SW'(sp_q);
          stk_wdata = o_img_q;
          sp_d      = sp_q + SPW'(1);
        end
        state_d = ppdr_pkg::ST_POP;
      end

      // Walk done: report, rewrite tables only if every point was reached
      ppdr_pkg::ST_FINISH: begin
        rsp_d.all_reached   = (next_q == n_q);
        rsp_d.reached_count = next_q;
        cnt_d               = '0;
        if (next_q == n_q) begin
          state_d = ppdr_pkg::ST_WR_FETCH;
        end else begin
          state_d = ppdr_pkg::ST_RESP;
        end
      end

      ppdr_pkg::ST_WR_FETCH: begin
        pt_addr  = AW'(cnt_q);
        lab_addr = AW'(cnt_q);
        state_d  = ppdr_pkg::ST_WR_MAPS;
      end

      ppdr_pkg::ST_WR_MAPS: begin
        lbl_d    = lab_rdata[LW-1:0];
        s_img_d  = pt_s_rdata;
        o_img_d  = pt_o_rdata;
        lab_addr = AW'(pt_s_rdata);
        state_d  = ppdr_pkg::ST_WR_MAPO;
      end

      ppdr_pkg::ST_WR_MAPO: begin
        ms_d     = ({1'b0, s_img_q} < n_q) ? lab_rdata[IW-1:0] : '0;
        lab_addr = AW'(o_img_q);
        state_d  = ppdr_pkg::ST_WR_STORE;
      end

      ppdr_pkg::ST_WR_STORE: begin
        rel_we      = 1'b1;
        rel_addr    = AW'(lbl_q);
        rel_o_wdata = ({1'b0, o_img_q} < n_q) ? lab_rdata[IW-1:0] : '0;
        cnt_d       = cnt_q + NW'(1);
        if (cnt_q == n_q - NW'(1)) begin
          state_d = ppdr_pkg::ST_RESP;
        end else begin
          state_d = ppdr_pkg::ST_WR_FETCH;
        end
      end

      ppdr_pkg::ST_RESP: begin
        state_d = ppdr_pkg::ST_IDLE;
      end

      default: begin
        state_d = ppdr_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == ppdr_pkg::ST_IDLE);
  assign done_o = (state_q == ppdr_pkg::ST_RESP);
  assign rsp_o  = rsp_q;

endmodule

[hdl/permutation_pair_dfs_relabel.sv]
// Top level: size register, request intake and result register.
//
// Requests arrive on in_valid_i/in_ready_o, one item each: load one point
// (entry_index, s_image, o_image), run the relabelling walk, or read one
// entry of the relabelled tables. Every request yields exactly one result
// item on out_valid_o/out_ready_i. The size register is written through
// cfg_valid_i/cfg_data_i, which is always ready; write it only while idle.
// A run clears the label store, walks the points reachable from point 0,
// closes the walk and hands over the result, and rewrites the tables
// when all points are reached. One item is in work at a time; the next
// is taken no earlier than that item's result. A stalled receiver holds
// the result in the output register and keeps in_ready_o low.
// Reset empties the output register, returns the sequencer to idle and sets
// the size to 256; point and result tables keep no reset value.
module permutation_pair_dfs_relabel #(
  parameter int unsigned MAX_POINTS = ppdr_pkg::MaxPointsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppdr_pkg::SizeW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ppdr_pkg::TypeW-1:0]     req_type_i,
  input  logic [ppdr_pkg::IdxW-1:0]      entry_index_i,
  input  logic [ppdr_pkg::ImgW-1:0]      s_image_i,
  input  logic [ppdr_pkg::ImgW-1:0]      o_image_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           all_reached_o,
  output logic [ppdr_pkg::SizeW-1:0]     reached_count_o,
  output logic [ppdr_pkg::ImgW-1:0]      new_s_o,
  output logic [ppdr_pkg::ImgW-1:0]      new_o_o
);

  logic [ppdr_pkg::SizeW-1:0] size_q;
  logic                       out_valid_q;
  ppdr_pkg::rsp_t             out_q;
  ppdr_pkg::cmd_t             cmd;
  ppdr_pkg::rsp_t             rsp;
  logic                       eng_idle, eng_done, start;

  // Size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= ppdr_pkg::SizeRst;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // Intake
  assign in_ready_o = eng_idle && (!out_valid_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  assign cmd.req_type    = ppdr_pkg::req_type_e'(req_type_i);
  assign cmd.entry_index = entry_index_i;
  assign cmd.s_image     = s_image_i;
  assign cmd.o_image     = o_image_i;
  assign cmd.size        = size_q;

  ppdr_engine #(.MAX_POINTS(MAX_POINTS)) u_engine (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .cmd_i   (cmd),
    .idle_o  (eng_idle),
    .done_o  (eng_done),
    .rsp_o   (rsp)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign all_reached_o   = out_q.all_reached;
  assign reached_count_o = out_q.reached_count;
  assign new_s_o         = out_q.new_s;
  assign new_o_o         = out_q.new_o;

endmodule

[test/tb_permutation_pair_dfs_relabel.sv]
// Self-checking testbench for the permutation pair depth-first relabelling block.
module tb_permutation_pair_dfs_relabel;
  import ppdr_pkg::*;

  localparam logic [TypeW-1:0] ReqUnknown = 2'd3;
  localparam int unsigned Points = MaxPointsDef;
  localparam int unsigned PhaseItems = 40;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned DirectedLen = 25;
  localparam int unsigned PhaseCount = 12;

  // One row of the directed list: either a size write or a request item
  typedef struct packed {
    logic             set_size;
    logic [SizeW-1:0] size;
    logic [TypeW-1:0] kind;
    logic [IdxW-1:0]  idx;
    logic [ImgW-1:0]  s_img;
    logic [ImgW-1:0]  o_img;
    logic             fixed;
    rsp_t             rsp;
  } stim_row_t;

  localparam rsp_t NoRsp = '0;

  localparam stim_row_t DirectedRows [DirectedLen] = '{
    // size from reset (256): a lone fixed point at 0 reaches one point only
    '{1'b0, 9'd0,   REQ_LOAD,   8'd0,   8'd0,   8'd0,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 9'd1, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   ReqUnknown, 8'd255, 8'd255, 8'd255, 1'b1, NoRsp},
    // three points, every one reached
    '{1'b1, 9'd3,   REQ_LOAD,   8'd0,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_LOAD,   8'd0,   8'd1,   8'd2,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_LOAD,   8'd1,   8'd2,   8'd0,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_LOAD,   8'd2,   8'd0,   8'd1,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 9'd3, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   REQ_READ,   8'd0,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_READ,   8'd1,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_READ,   8'd2,   8'd0,   8'd0,   1'b0, NoRsp},
    // image beyond the size: not followed, written back as 0
    '{1'b0, 9'd0,   REQ_LOAD,   8'd2,   8'd255, 8'd1,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 9'd3, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   REQ_READ,   8'd1,   8'd0,   8'd0,   1'b0, NoRsp},
    // partial reach leaves the tables untouched
    '{1'b0, 9'd0,   REQ_LOAD,   8'd0,   8'd0,   8'd0,   1'b1, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 9'd1, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   REQ_READ,   8'd0,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_LOAD,   8'd255, 8'd0,   8'd255, 1'b1, NoRsp},
    // size 0 behaves as one point
    '{1'b1, 9'd0,   REQ_LOAD,   8'd0,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b1, 9'd1, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   REQ_READ,   8'd0,   8'd0,   8'd0,   1'b1, NoRsp},
    // read above the size still returns the stored entry
    '{1'b0, 9'd0,   REQ_READ,   8'd2,   8'd0,   8'd0,   1'b0, NoRsp},
    // oversize setting saturates at 256
    '{1'b1, 9'd511, REQ_LOAD,   8'd0,   8'd0,   8'd0,   1'b0, NoRsp},
    '{1'b0, 9'd0,   REQ_RUN,    8'd0,   8'd0,   8'd0,   1'b1, '{1'b0, 9'd1, 8'd0, 8'd0}},
    '{1'b0, 9'd0,   ReqUnknown, 8'd0,   8'd0,   8'd0,   1'b1, NoRsp}
  };

  localparam logic [SizeW-1:0] PhaseSizes [PhaseCount] = '{
    9'd5, 9'd1, 9'd2, 9'd16, 9'd0, 9'd64, 9'd256, 9'd9, 9'd511, 9'd33, 9'd300, 9'd4
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [TypeW-1:0] req_type_i = '0;
  logic [IdxW-1:0]  entry_index_i = '0;
  logic [ImgW-1:0]  s_image_i = '0;
  logic [ImgW-1:0]  o_image_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             all_reached_o;
  logic [SizeW-1:0] reached_count_o;
  logic [ImgW-1:0]  new_s_o;
  logic [ImgW-1:0]  new_o_o;

  permutation_pair_dfs_relabel dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .entry_index_i   (entry_index_i),
    .s_image_i       (s_image_i),
    .o_image_i       (o_image_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .all_reached_o   (all_reached_o),
    .reached_count_o (reached_count_o),
    .new_s_o         (new_s_o),
    .new_o_o         (new_o_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: loaded points, relabelled tables, size setting
  logic [ImgW-1:0]  pt_s [Points];
  logic [ImgW-1:0]  pt_o [Points];
  bit               pt_loaded [Points];
  logic [ImgW-1:0]  tbl_s [Points];
  logic [ImgW-1:0]  tbl_o [Points];
  bit               tbl_written [Points];
  logic [SizeW-1:0] size_reg = SizeRst;
  logic [ImgW-1:0]  scratch [Points];

  rsp_t        pending_results [$];
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned idle_pct = 25;
  int unsigned hold_left = 0;

  function automatic int unsigned eff_points();
    if (size_reg == '0) return 1;
    if (size_reg > SizeW'(Points)) return Points;
    return int'(size_reg);
  endfunction

  function automatic bit all_loaded(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if (!pt_loaded[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Depth-first walk from point 0, O successor before S successor;
  // rewrites the tables only when every point was labelled
  function automatic int unsigned relabel_walk(input int unsigned n);
    int unsigned lbl [Points];
    bit          seen [Points];
    int unsigned stk [$];
    int unsigned p;
    int unsigned nxt;
    int unsigned d;
    nxt = 0;
    stk.push_back(0);
    while (stk.size() > 0) begin
      p = stk.pop_back();
      if (p >= n || seen[p]) continue;
      seen[p] = 1'b1;
      lbl[p] = nxt;
      nxt++;
      if (pt_s[p] < n && stk.size() < Points + 1) stk.push_back(int'(pt_s[p]));
      if (pt_o[p] < n && stk.size() < Points + 1) stk.push_back(int'(pt_o[p]));
    end
    if (nxt == n) begin
      for (int unsigned i = 0; i < n; i++) begin
        d = lbl[i];
        tbl_s[d] = (pt_s[i] < n) ? ImgW'(lbl[pt_s[i]]) : '0;
        tbl_o[d] = (pt_o[i] < n) ? ImgW'(lbl[pt_o[i]]) : '0;
        tbl_written[d] = 1'b1;
      end
    end
    return nxt;
  endfunction

  function automatic rsp_t predict_response(input logic [TypeW-1:0] kind,
                                            input logic [IdxW-1:0] idx,
                                            input logic [ImgW-1:0] s_img,
                                            input logic [ImgW-1:0] o_img);
    rsp_t        r;
    int unsigned n;
    int unsigned cnt;
    r = '0;
    case (kind)
      REQ_LOAD: begin
        pt_s[idx] = s_img;
        pt_o[idx] = o_img;
        pt_loaded[idx] = 1'b1;
      end
      REQ_RUN: begin
        n = eff_points();
        cnt = relabel_walk(n);
        r.all_reached = (cnt == n);
        r.reached_count = SizeW'(cnt);
      end
      REQ_READ: begin
        r.new_s = tbl_s[idx];
        r.new_o = tbl_o[idx];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ImgW-1:0] rnd8();
    return ImgW'($urandom_range(255));
  endfunction

  // Random permutation of 0..n-1 into scratch
  function automatic void shuffle_scratch(input int unsigned n);
    int unsigned j;
    logic [ImgW-1:0] t;
    for (int unsigned k = 0; k < n; k++) scratch[k] = ImgW'(k);
    for (int unsigned k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = scratch[k];
      scratch[k] = scratch[j];
      scratch[j] = t;
    end
  endfunction

  // Only entries of the relabelled tables that were written get read
  function automatic bit pick_entry(input int unsigned n, output logic [IdxW-1:0] idx);
    int unsigned c;
    idx = '0;
    for (int t = 0; t < 16; t++) begin
      if ($urandom_range(7) == 0) c = Points - 1;
      else if ($urandom_range(3) == 0) c = $urandom_range(Points - 1);
      else c = $urandom_range(n - 1);
      if (tbl_written[c]) begin
        idx = IdxW'(c);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Drive one item, hold it until taken, then log what should come back
  task automatic send_item(input logic [TypeW-1:0] kind, input logic [IdxW-1:0] idx,
                           input logic [ImgW-1:0] s_img, input logic [ImgW-1:0] o_img,
                           input bit fixed, input rsp_t fixed_rsp);
    rsp_t guess;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_index_i <= idx;
    s_image_i     <= s_img;
    o_image_i     <= o_img;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_response(kind, idx, s_img, o_img);
    pending_results.push_back(fixed ? fixed_rsp : guess);
    items_sent++;
  endtask

  task automatic send_bare(input logic [TypeW-1:0] kind);
    send_item(kind, rnd8(), rnd8(), rnd8(), 1'b0, NoRsp);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_size(input logic [SizeW-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    size_reg = v;
  endtask

  task automatic read_some(input int unsigned n, input int unsigned cnt);
    logic [IdxW-1:0] idx;
    repeat (cnt) begin
      if (pick_entry(n, idx)) send_item(REQ_READ, idx, rnd8(), rnd8(), 1'b0, NoRsp);
    end
  endtask

  // Full load of both maps in random point order
  task automatic load_tables(input int unsigned n);
    logic [ImgW-1:0] s_map [Points];
    logic [ImgW-1:0] o_map [Points];
    int unsigned style;
    int unsigned i;
    style = $urandom_range(9);
    shuffle_scratch(n);
    s_map = scratch;
    shuffle_scratch(n);
    o_map = scratch;
    shuffle_scratch(n);
    for (int unsigned k = 0; k < n; k++) begin
      i = scratch[k];
      if (style < 2) begin
        // plain maps rather than permutations
        s_map[i] = ImgW'($urandom_range(n - 1));
        o_map[i] = ImgW'($urandom_range(n - 1));
      end else if (style < 4 && $urandom_range(7) == 0) begin
        o_map[i] = rnd8();
      end
      send_item(REQ_LOAD, IdxW'(i), s_map[i], o_map[i], 1'b0, NoRsp);
    end
  endtask

  // Swap the images of two points, keeping the maps mostly bijective
  task automatic swap_points(input int unsigned n);
    int unsigned a;
    int unsigned b;
    int unsigned which;
    logic [ImgW-1:0] sa, oa, sb, ob;
    a = $urandom_range(n - 1);
    b = $urandom_range(n - 1);
    which = $urandom_range(3);
    sa = pt_s[b];
    sb = pt_s[a];
    oa = pt_o[a];
    ob = pt_o[b];
    if (which == 0) begin
      sa = pt_s[a];
      sb = pt_s[b];
    end
    if (which != 1) begin
      oa = pt_o[b];
      ob = pt_o[a];
    end
    if (which == 3) sa = rnd8();
    if ($urandom_range(1) == 0) begin
      send_item(REQ_LOAD, IdxW'(a), sa, oa, 1'b0, NoRsp);
      send_item(REQ_LOAD, IdxW'(b), sb, ob, 1'b0, NoRsp);
    end else begin
      send_item(REQ_LOAD, IdxW'(b), sb, ob, 1'b0, NoRsp);
      send_item(REQ_LOAD, IdxW'(a), sa, oa, 1'b0, NoRsp);
    end
  endtask

  task automatic noise_burst(input int unsigned n);
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(3))
        0: send_item(REQ_LOAD, rnd8(), rnd8(), rnd8(), 1'b0, NoRsp);
        1: read_some(n, 1);
        2: if (all_loaded(n)) send_bare(REQ_RUN);
        default: send_bare(ReqUnknown);
      endcase
    end
  endtask

  // Receiver: ready dropped in random bursts
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      hold_left = $urandom_range(5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic note_mismatch(input string field, input logic [SizeW-1:0] want,
                               input logic [SizeW-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Result checker: each taken item against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result item with none outstanding", $time);
      end else begin
        want = pending_results.pop_front();
        if (all_reached_o !== want.all_reached)
          note_mismatch("all_reached", SizeW'(want.all_reached), SizeW'(all_reached_o));
        if (reached_count_o !== want.reached_count)
          note_mismatch("reached_count", want.reached_count, reached_count_o);
        if (new_s_o !== want.new_s) note_mismatch("new_s", SizeW'(want.new_s), SizeW'(new_s_o));
        if (new_o_o !== want.new_o) note_mismatch("new_o", SizeW'(want.new_o), SizeW'(new_o_o));
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t   row;
    int unsigned n;
    int unsigned roll;
    int unsigned phase_end;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed list
    for (int r = 0; r < DirectedLen; r++) begin
      row = DirectedRows[r];
      if (row.set_size) write_size(row.size);
      else send_item(row.kind, row.idx, row.s_img, row.o_img, row.fixed, row.rsp);
    end

    // random phases, one size setting each; the last one runs without idling
    for (int ph = 0; ph < PhaseCount; ph++) begin
      write_size(PhaseSizes[ph]);
      if (ph == PhaseCount - 1) idle_pct = 0;
      else idle_pct = ($urandom_range(3) == 0) ? 0 : 25;
      n = eff_points();
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          if (n > 48 && all_loaded(n) && $urandom_range(3) != 0) swap_points(n);
          else load_tables(n);
          send_bare(REQ_RUN);
          read_some(n, $urandom_range(4, 1));
        end else if (roll < 85) begin
          noise_burst(n);
        end else if (roll < 95) begin
          read_some(n, $urandom_range(3, 1));
        end else begin
          send_bare(ReqUnknown);
        end
        if ($urandom_range(39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) $display("tb_permutation_pair_dfs_relabel: PASS");
    else $display("tb_permutation_pair_dfs_relabel: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("tb_permutation_pair_dfs_relabel: FAIL");
    $finish;
  end

endmodule

[sim.f]
hdl/ppdr_pkg.sv
hdl/ppdr_ram.sv
hdl/ppdr_engine.sv
hdl/permutation_pair_dfs_relabel.sv
test/tb_permutation_pair_dfs_relabel.sv
